@@ rtl/core/cfpf_pkg.sv @@
// ----------------------------------------------------------------------------
// cfpf_pkg
// Shared types, constants and helpers of the command frame parser.
// ----------------------------------------------------------------------------
package cfpf_pkg;

	localparam int QUEUE_SLOTS = 8;
	localparam int QIDX_W      = $clog2(QUEUE_SLOTS);

	localparam logic [2:0] AWAIT_ID     = 3'd4;
	localparam logic [2:0] LAST_PAYLOAD = 3'd3;

	localparam int          CFG_ADDR_W = 3;
	localparam logic        REG_ROLL   = 1'b0;
	localparam logic        REG_PITCH  = 1'b1;
	localparam logic [7:0]  ROLL_RST   = 8'd1;
	localparam logic [7:0]  PITCH_RST  = 8'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic [QIDX_W-1:0] qidx_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_PUSH,
		ACT_POP
	} act_kind_t;

	typedef struct packed {
		act_kind_t   kind;
		logic [7:0]  id;
		logic [31:0] payload;
	} act_t;

	function automatic qidx_t ring_next(input qidx_t pos);
		if (pos == qidx_t'(QUEUE_SLOTS - 1)) begin
			return '0;
		end
		return pos + qidx_t'(1);
	endfunction

endpackage

@@ rtl/core/command_frame_parser_fifo_top.sv @@
// ----------------------------------------------------------------------------
// Path: an input transfer is written into the action queue, then executed by
// the command ring into the output register, from which it can transfer.
// Throughput: one item per cycle without stalls; the two-entry action queue
// and the output register let input and output stall independently.
// Reset: parser awaits an id byte, last payload zero, ring empty, roll and
// pitch codes 1 and 2; ring contents are not cleared.
// ----------------------------------------------------------------------------
// command_frame_parser_fifo_top
// Serial command framer with an eight-slot command ring and APB code registers.
// ----------------------------------------------------------------------------
module command_frame_parser_fifo_top import cfpf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  cmd_pushed,
	output logic                  cmd_dropped,
	output logic                  pop_valid,
	output logic [7:0]            popped_id,
	output logic [31:0]           popped_payload,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [7:0] roll_code_q;
	logic [7:0] pitch_code_q;
	logic       cfg_wr;
	logic       reg_sel;
	logic       act_push;
	logic       act_full;
	logic       act_empty;
	logic       act_pop;
	act_t       front_act;
	act_t       head_act;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_code_q  <= ROLL_RST;
			pitch_code_q <= PITCH_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ROLL:  roll_code_q  <= pwdata[7:0];
				REG_PITCH: pitch_code_q <= pwdata[7:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ROLL:  prdata = {24'd0, roll_code_q};
			REG_PITCH: prdata = {24'd0, pitch_code_q};
			default:   prdata = '0;
		endcase
	end

	cfpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.rx_byte    (rx_byte),
		.roll_code  (roll_code_q),
		.pitch_code (pitch_code_q),
		.act_full   (act_full),
		.act_push   (act_push),
		.act        (front_act)
	);

	cfpf_act_fifo u_act_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (act_push),
		.push_act (front_act),
		.full     (act_full),
		.pop      (act_pop),
		.empty    (act_empty),
		.head_act (head_act)
	);

	cfpf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.act_empty      (act_empty),
		.act            (head_act),
		.act_pop        (act_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cmd_pushed     (cmd_pushed),
		.cmd_dropped    (cmd_dropped),
		.pop_valid      (pop_valid),
		.popped_id      (popped_id),
		.popped_payload (popped_payload)
	);

endmodule

@@ rtl/core/cfpf_front.sv @@
// ----------------------------------------------------------------------------
// cfpf_front
// Frames received bytes into commands and issues one action per transfer.
// ----------------------------------------------------------------------------
module cfpf_front import cfpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  roll_code,
	input  logic [7:0]  pitch_code,
	input  logic        act_full,
	output logic        act_push,
	output act_t        act
);

	logic [2:0]  bytes_left_q;
	logic [7:0]  current_id_q;
	logic [31:0] assembly_word_q;
	logic [31:0] last_payload_q;
	logic [31:0] assembly_next;
	logic        awaiting_id;
	logic        id_match;

	assign in_stall      = act_full;
	assign act_push      = in_valid && !act_full;
	assign assembly_next = {assembly_word_q[23:0], rx_byte};
	assign awaiting_id   = bytes_left_q > LAST_PAYLOAD;
	assign id_match      = (rx_byte == roll_code) || (rx_byte == pitch_code);

	always_comb begin
		act.kind    = ACT_NONE;
		act.id      = current_id_q;
		act.payload = assembly_next;
		if (operation == OP_POP) begin
			act.kind = ACT_POP;
		end else if (awaiting_id) begin
			act.id      = rx_byte;
			act.payload = last_payload_q;
			if (!id_match) begin
				act.kind = ACT_PUSH;
			end
		end else if (bytes_left_q == 3'd0) begin
			act.kind = ACT_PUSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q    <= AWAIT_ID;
			current_id_q    <= '0;
			assembly_word_q <= '0;
			last_payload_q  <= '0;
		end else if (act_push && operation == OP_BYTE) begin
			if (awaiting_id) begin
				current_id_q <= rx_byte;
				if (id_match) begin
					bytes_left_q <= LAST_PAYLOAD;
				end
			end else begin
				assembly_word_q <= assembly_next;
				if (bytes_left_q == 3'd0) begin
					bytes_left_q   <= AWAIT_ID;
					last_payload_q <= assembly_next;
				end else begin
					bytes_left_q <= bytes_left_q - 3'd1;
				end
			end
		end
	end

	a_bytes_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q <= AWAIT_ID)
		else $error("parser byte count out of range");

endmodule

@@ rtl/core/cfpf_act_fifo.sv @@
// ----------------------------------------------------------------------------
// cfpf_act_fifo
// Two-entry action queue between the parser and the command ring.
// ----------------------------------------------------------------------------
module cfpf_act_fifo import cfpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  act_t push_act,
	output logic full,
	input  logic pop,
	output logic empty,
	output act_t head_act
);

	act_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign head_act = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("action queue count overflow");

	a_ptr_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("action queue pointers disagree with count");

endmodule

@@ rtl/core/cfpf_back.sv @@
// ----------------------------------------------------------------------------
// cfpf_back
// Command ring: executes push and pop actions and holds the result register.
// ----------------------------------------------------------------------------
module cfpf_back import cfpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        act_empty,
	input  act_t        act,
	output logic        act_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        cmd_pushed,
	output logic        cmd_dropped,
	output logic        pop_valid,
	output logic [7:0]  popped_id,
	output logic [31:0] popped_payload
);

	logic [39:0] ring_mem [QUEUE_SLOTS];
	qidx_t       head_q;
	qidx_t       tail_q;
	logic        out_valid_q;
	logic        cmd_pushed_q;
	logic        cmd_dropped_q;
	logic        pop_valid_q;
	logic [7:0]  popped_id_q;
	logic [31:0] popped_payload_q;
	logic        ring_full;
	logic        ring_empty;
	logic        do_write;
	logic        do_read;

	assign act_pop    = !act_empty && (!out_valid_q || !out_stall);
	assign ring_full  = ring_next(tail_q) == head_q;
	assign ring_empty = head_q == tail_q;
	assign do_write   = act_pop && act.kind == ACT_PUSH && !ring_full;
	assign do_read    = act_pop && act.kind == ACT_POP && !ring_empty;

	always_ff @(posedge clk) begin
		if (do_write) begin
			ring_mem[tail_q] <= {act.id, act.payload};
		end
	end

	always_ff @(posedge clk) begin
		if (act_pop) begin
			if (do_read) begin
				{popped_id_q, popped_payload_q} <= ring_mem[head_q];
			end else begin
				popped_id_q      <= '0;
				popped_payload_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			tail_q        <= '0;
			out_valid_q   <= 1'b0;
			cmd_pushed_q  <= 1'b0;
			cmd_dropped_q <= 1'b0;
			pop_valid_q   <= 1'b0;
		end else begin
			if (do_write) begin
				tail_q <= ring_next(tail_q);
			end
			if (do_read) begin
				head_q <= ring_next(head_q);
			end
			if (act_pop) begin
				out_valid_q   <= 1'b1;
				cmd_pushed_q  <= do_write;
				cmd_dropped_q <= act.kind == ACT_PUSH && ring_full;
				pop_valid_q   <= do_read;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign cmd_pushed     = cmd_pushed_q;
	assign cmd_dropped    = cmd_dropped_q;
	assign pop_valid      = pop_valid_q;
	assign popped_id      = popped_id_q;
	assign popped_payload = popped_payload_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $countones({cmd_pushed_q, cmd_dropped_q, pop_valid_q}) <= 1)
		else $error("more than one result flag set");

	a_push_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> !ring_empty)
		else $error("ring empty after a stored command");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(act_pop && act.kind == ACT_PUSH && ring_full) |=> $stable(tail_q))
		else $error("tail moved on a dropped command");

endmodule
